>>> rtl/rtp_jitter_buffer_gap_fill_core_assert.svh
// Assertion macros for the jitter buffer core.
`ifndef RTP_JITTER_BUFFER_GAP_FILL_CORE_ASSERT_SVH
`define RTP_JITTER_BUFFER_GAP_FILL_CORE_ASSERT_SVH

`define RJB_ASSERT(NAME, PROP, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) PROP) \
    else $error(MSG);

`define RJB_NEVER(NAME, EXPR, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) !(EXPR)) \
    else $error(MSG);

`endif

>>> rtl/rjb_pkg.sv
package rjb_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [1:0] REG_AUDIO_PT   = 2'd0;
  localparam logic [1:0] REG_MIN_FILLED = 2'd1;
  localparam logic [1:0] REG_FILL_THR   = 2'd2;

  localparam logic [CFG_W-1:0] AUDIO_PT_RESET   = 7'd64;
  localparam logic [CFG_W-1:0] MIN_FILLED_RESET = 7'd1;
  localparam logic [CFG_W-1:0] FILL_THR_RESET   = 7'd16;
  localparam logic [CFG_W-1:0] DUMMY_PT_OFFSET  = 7'd2;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_READ  = 1'b1;

  localparam logic [2:0] WS_QUEUED   = 3'd0;
  localparam logic [2:0] WS_DUMMY    = 3'd1;
  localparam logic [2:0] WS_BAD_TYPE = 3'd2;
  localparam logic [2:0] WS_FULL     = 3'd3;
  localparam logic [2:0] WS_OLD      = 3'd4;

  localparam logic [1:0] RS_EMPTY  = 2'd0;
  localparam logic [1:0] RS_NORMAL = 2'd1;
  localparam logic [1:0] RS_PILING = 2'd2;

  // wrap window for sequence number comparison
  localparam logic [15:0] SEQ_WRAP_LO = 16'd8;
  localparam logic [15:0] SEQ_WRAP_HI = 16'hFFF8;

  typedef struct packed {
    logic        operation;
    logic [15:0] seq_num;
    logic [7:0]  payload_type;
    logic [15:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  write_status;
    logic [15:0] gap_count;
    logic [1:0]  read_status;
    logic        frame_valid;
    logic        frame_lost;
    logic [15:0] frame_tag;
    logic [15:0] frame_seq;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] audio_payload_type;
    logic [CFG_W-1:0] min_filled;
    logic [CFG_W-1:0] fill_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_PKT,
    CMD_DROP,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  wstat;
    logic [15:0] seq;
    logic [15:0] tag;
  } cmd_t;

  typedef struct packed {
    logic        lost;
    logic [15:0] seq;
    logic [15:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GAP,
    BK_RD
  } bk_state_e;

endpackage

>>> rtl/rjb_ram.sv
module rjb_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rjb_front.sv
module rjb_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rjb_pkg::in_item_t in_item_i,
  input  rjb_pkg::cfg_t     cfg_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output rjb_pkg::cmd_t     cmd_o
);
  import rjb_pkg::*;

  logic [CFG_W-1:0] pt;
  logic [CFG_W-1:0] dummy_pt;

  assign pt       = in_item_i.payload_type[CFG_W-1:0];
  assign dummy_pt = cfg_i.audio_payload_type + DUMMY_PT_OFFSET;

  always_comb begin
    cmd_o       = '0;
    cmd_o.seq   = in_item_i.seq_num;
    cmd_o.tag   = in_item_i.payload_tag;
    cmd_o.kind  = CMD_PKT;
    cmd_o.wstat = WS_QUEUED;
    if (in_item_i.operation == OP_READ) begin
      cmd_o.kind = CMD_READ;
    end else if (pt == dummy_pt) begin
      cmd_o.kind  = CMD_DROP;
      cmd_o.wstat = WS_DUMMY;
    end else if (pt != cfg_i.audio_payload_type) begin
      cmd_o.kind  = CMD_DROP;
      cmd_o.wstat = WS_BAD_TYPE;
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

>>> rtl/rjb_cmd_fifo.sv
module rjb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rjb_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rjb_pkg::cmd_t pop_data_o
);
  import rjb_pkg::*;

  localparam int unsigned QW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          slot_q [CMD_FIFO_DEPTH];
  logic [QW-1:0] wr_q, wr_d;
  logic [QW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(CMD_FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? QW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop ? QW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/rjb_back.sv
`include "rtp_jitter_buffer_gap_fill_core_assert.svh"

module rjb_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rjb_pkg::cfg_t              cfg_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  rjb_pkg::cmd_t              cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rjb_pkg::out_item_t         out_item_o,
  output logic                       ram_we_o,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output rjb_pkg::entry_t            ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr_o,
  input  rjb_pkg::entry_t            ram_rdata_i
);
  import rjb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (FW > CFG_W) ? FW : CFG_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    return r;
  endfunction

  bk_state_e     state_q, state_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   last_seq_q, last_seq_d;
  logic          have_last_q, have_last_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic [15:0]   mark_seq_q, mark_seq_d;
  logic [15:0]   pkt_seq_q, pkt_seq_d;
  logic [15:0]   pkt_tag_q, pkt_tag_d;
  logic [15:0]   gap_q, gap_d;
  logic [1:0]    rstat_q, rstat_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q, out_item_d;

  logic          take;
  logic          full;
  logic          newer;
  logic [15:0]   gap;
  logic [FW-1:0] n_mark;
  logic [XW-1:0] fill_x, min_x, thr_x;
  logic          push_en;
  entry_t        push_entry;
  logic          rd_en;
  out_item_t     res;
  logic          load;
  logic [1:0]    rs;

  assign cmd_ready_o = (state_q == BK_IDLE) && (!out_valid_q || out_ready_i);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign full        = fill_q == FW'(DEPTH);
  assign newer       = (cmd_i.seq > last_seq_q) ||
                       ((cmd_i.seq < SEQ_WRAP_LO) && (last_seq_q > SEQ_WRAP_HI));
  assign gap         = 16'(cmd_i.seq - last_seq_q - 16'd1);
  assign n_mark      = (gap > 16'(DEPTH)) ? FW'(DEPTH) : FW'(gap);
  assign fill_x      = XW'(fill_q);
  assign min_x       = XW'(cfg_i.min_filled);
  assign thr_x       = XW'(cfg_i.fill_threshold);
  assign rs          = (fill_x > thr_x) ? RS_PILING : RS_NORMAL;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          if (cmd_i.kind == CMD_PKT && !full && have_last_q && newer && gap != '0) begin
            state_d = BK_GAP;
          end else if (cmd_i.kind == CMD_READ && fill_q != '0 && fill_x >= min_x) begin
            state_d = BK_RD;
          end
        end
      end
      BK_GAP: begin
        if (cnt_q == '0) begin
          state_d = BK_IDLE;
        end
      end
      BK_RD: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    fill_d      = fill_q;
    last_seq_d  = last_seq_q;
    have_last_d = have_last_q;
    cnt_d       = cnt_q;
    mark_seq_d  = mark_seq_q;
    pkt_seq_d   = pkt_seq_q;
    pkt_tag_d   = pkt_tag_q;
    gap_d       = gap_q;
    rstat_d     = rstat_q;
    push_en     = 1'b0;
    push_entry  = '0;
    rd_en       = 1'b0;
    res         = '0;
    load        = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          case (cmd_i.kind)
            CMD_DROP: begin
              res.write_status = cmd_i.wstat;
              load             = 1'b1;
            end
            CMD_PKT: begin
              if (full) begin
                res.write_status = WS_FULL;
                load             = 1'b1;
              end else if (!have_last_q || (newer && gap == '0)) begin
                last_seq_d  = cmd_i.seq;
                have_last_d = 1'b1;
                push_en     = 1'b1;
                push_entry  = '{lost: 1'b0, seq: cmd_i.seq, tag: cmd_i.tag};
                res.write_status = WS_QUEUED;
                load        = 1'b1;
              end else if (newer) begin
                last_seq_d = cmd_i.seq;
                cnt_d      = n_mark;
                mark_seq_d = 16'(cmd_i.seq - 16'(n_mark));
                pkt_seq_d  = cmd_i.seq;
                pkt_tag_d  = cmd_i.tag;
                gap_d      = gap;
              end else begin
                res.write_status = WS_OLD;
                load             = 1'b1;
              end
            end
            CMD_READ: begin
              if (fill_q == '0) begin
                res.read_status = RS_EMPTY;
                load            = 1'b1;
              end else if (fill_x >= min_x) begin
                rd_en    = 1'b1;
                rd_ptr_d = ptr_inc(rd_ptr_q);
                fill_d   = FW'(fill_q - 1'b1);
                rstat_d  = rs;
              end else begin
                res.read_status = rs;
                load            = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_GAP: begin
        push_en = 1'b1;
        if (cnt_q != '0) begin
          push_entry = '{lost: 1'b1, seq: mark_seq_q, tag: 16'd0};
          mark_seq_d = 16'(mark_seq_q + 16'd1);
          cnt_d      = FW'(cnt_q - 1'b1);
        end else begin
          push_entry       = '{lost: 1'b0, seq: pkt_seq_q, tag: pkt_tag_q};
          res.write_status = WS_QUEUED;
          res.gap_count    = gap_q;
          load             = 1'b1;
        end
      end
      BK_RD: begin
        res.read_status = rstat_q;
        res.frame_valid = 1'b1;
        res.frame_lost  = ram_rdata_i.lost;
        res.frame_tag   = ram_rdata_i.lost ? 16'd0 : ram_rdata_i.tag;
        res.frame_seq   = ram_rdata_i.seq;
        load            = 1'b1;
      end
      default: begin
      end
    endcase

    // a write into a full ring drops the oldest entry
    if (push_en) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
      if (full) begin
        rd_ptr_d = ptr_inc(rd_ptr_q);
      end else begin
        fill_d = FW'(fill_q + 1'b1);
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      last_seq_q  <= '0;
      have_last_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      last_seq_q  <= last_seq_d;
      have_last_q <= have_last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_seq_q <= mark_seq_d;
    pkt_seq_q  <= pkt_seq_d;
    pkt_tag_q  <= pkt_tag_d;
    gap_q      <= gap_d;
    rstat_q    <= rstat_d;
    out_item_q <= out_item_d;
  end

  assign ram_we_o    = push_en;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = push_entry;
  assign ram_re_o    = rd_en;
  assign ram_raddr_o = rd_ptr_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `RJB_NEVER(a_fill_max, fill_q > FW'(DEPTH), "fill count above ring depth")
  `RJB_ASSERT(a_empty_ptrs, (fill_q == '0) |-> (rd_ptr_q == wr_ptr_q), "empty ring, pointers differ")
  `RJB_ASSERT(a_gap_no_out, (state_q == BK_GAP) |-> !out_valid_q, "result pending during gap fill")
  `RJB_ASSERT(a_rd_result, (state_q == BK_RD) |=> out_valid_q, "read result not produced")

endmodule

>>> rtl/rtp_jitter_buffer_gap_fill_core.sv
// Audio jitter buffer with lost-frame gap fill. Items enter on the in channel (packet
// arrival or read request) and each gives exactly one result item on the out channel,
// in order. Input items are classified by payload type on entry and wait in a
// two-entry command queue; the back end runs them one at a time against a ring of
// DEPTH entries held in a single-port-write RAM with registered read. A dropped,
// rejected or directly queued packet loads its result in the cycle that takes it, a
// read that pops answers from the registered RAM read, and a newer packet with a gap
// of g > 0 writes min(g, DEPTH) lost marks, then the packet, one ring write per cycle.
// Results sit in an output register, so the back end moves to the next item while a
// result is being taken.
// Registers: 0x0 audio payload type (dummy type is that value plus two, mod 128),
// 0x4 least fill for a read to pop, 0x8 fill above which reads report piling up.
module rtp_jitter_buffer_gap_fill_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rjb_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [rjb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [rjb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  rjb_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output rjb_pkg::out_item_t                   out_item_o
);
  import rjb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  cfg_t          cfg_q, cfg_d;
  logic          cfg_we;
  logic [1:0]    reg_idx;

  logic          fr_valid, fr_ready;
  cmd_t          fr_cmd;
  logic          q_valid, q_ready;
  cmd_t          q_cmd;

  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_idx)
        REG_AUDIO_PT:   cfg_d.audio_payload_type = pwdata[CFG_W-1:0];
        REG_MIN_FILLED: cfg_d.min_filled         = pwdata[CFG_W-1:0];
        REG_FILL_THR:   cfg_d.fill_threshold     = pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AUDIO_PT:   prdata = APB_DATA_W'(cfg_q.audio_payload_type);
      REG_MIN_FILLED: prdata = APB_DATA_W'(cfg_q.min_filled);
      REG_FILL_THR:   prdata = APB_DATA_W'(cfg_q.fill_threshold);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.audio_payload_type <= AUDIO_PT_RESET;
      cfg_q.min_filled         <= MIN_FILLED_RESET;
      cfg_q.fill_threshold     <= FILL_THR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rjb_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  rjb_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  rjb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  rjb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
